// ----- hdl/pam_pkg.sv -----
// Package for the pointer activity meter.
// Holds the event codes, register indexes, widths, state types and the
// request and response structs of the distance unit. Depends on nothing.
package pam_pkg;

  localparam int DELTA_W    = 15;
  localparam int SUM_W      = 31;
  localparam int ROOT_W     = 16;
  localparam int CNT_W      = 4;
  localparam int SQ_STEPS   = 15;
  localparam int ROOT_STEPS = 16;

  localparam int ACC_W = 48;
  localparam int CNT32_W = 32;
  localparam int SEC_W = 39;
  localparam int REM_W = 10;

  localparam logic [SEC_W-1:0] SEC_MAX        = 39'd281474976710;
  localparam logic [REM_W-1:0] REM_AT_SAT     = 10'd655;
  localparam logic [REM_W:0]   MS_PER_SEC     = 11'd1000;
  localparam logic [31:0]      GAP_LIMIT      = 32'd1000;

  localparam logic [0:0]  RESET_ENABLE     = 1'b1;
  localparam logic [7:0]  RESET_MIN_STEP   = 8'd3;
  localparam logic [15:0] RESET_JUMP_LIMIT = 16'd10000;

  localparam logic [1:0] REQ_MOVE   = 2'd0;
  localparam logic [1:0] REQ_BUTTON = 2'd1;
  localparam logic [1:0] REQ_KEY    = 2'd2;

  localparam logic [1:0] CFG_IDX_ENABLE     = 2'd0;
  localparam logic [1:0] CFG_IDX_MIN_STEP   = 2'd1;
  localparam logic [1:0] CFG_IDX_JUMP_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIST,
    ST_FINISH
  } pam_state_t;

  typedef enum logic [1:0] {
    DIST_IDLE,
    DIST_SQUARE,
    DIST_ROOT
  } dist_phase_t;

  typedef struct packed {
    logic               start;
    logic [DELTA_W-1:0] dx;
    logic [DELTA_W-1:0] dy;
  } dist_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] hypot;
  } dist_rsp_t;

endpackage

// ----- hdl/pam_dist.sv -----
// Serial distance unit: floor(sqrt(dx*dx + dy*dy)) for 15-bit deltas.
// Squares both deltas by bit-serial shift and add, then takes the root one
// result bit per cycle. Depends on pam_pkg.
module pam_dist (
  input  logic                clk,
  input  logic                rst_n,
  input  pam_pkg::dist_req_t  req,
  output pam_pkg::dist_rsp_t  rsp
);
  import pam_pkg::*;

  localparam logic [SUM_W-1:0] ROOT_BIT0 = {1'b1, {(SUM_W-1){1'b0}}};

  dist_phase_t        phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DELTA_W-1:0] mx_r, mx_nxt, my_r, my_nxt;
  logic [SUM_W-1:0]   ax_r, ax_nxt, ay_r, ay_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W-1:0]   bit_r, bit_nxt;
  logic [SUM_W-1:0]   res_r, res_nxt;
  logic               done_r, done_nxt;

  always_comb begin
    logic [SUM_W:0]   trial;
    logic             root_ge;
    logic [SUM_W-1:0] part_x;
    logic [SUM_W-1:0] part_y;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    mx_nxt    = mx_r;
    my_nxt    = my_r;
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    sum_nxt   = sum_r;
    bit_nxt   = bit_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    trial     = {1'b0, res_r} + {1'b0, bit_r};
    root_ge   = ({1'b0, sum_r} >= trial);
    part_x    = mx_r[0] ? ax_r : '0;
    part_y    = my_r[0] ? ay_r : '0;
    case (phase_r)
      DIST_IDLE: begin
        if (req.start) begin
          mx_nxt    = req.dx;
          my_nxt    = req.dy;
          ax_nxt    = {{(SUM_W-DELTA_W){1'b0}}, req.dx};
          ay_nxt    = {{(SUM_W-DELTA_W){1'b0}}, req.dy};
          sum_nxt   = '0;
          cnt_nxt   = CNT_W'(SQ_STEPS - 1);
          phase_nxt = DIST_SQUARE;
        end
      end
      DIST_SQUARE: begin
        sum_nxt = sum_r + part_x + part_y;
        ax_nxt  = ax_r << 1;
        ay_nxt  = ay_r << 1;
        mx_nxt  = mx_r >> 1;
        my_nxt  = my_r >> 1;
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(ROOT_STEPS - 1);
          bit_nxt   = ROOT_BIT0;
          res_nxt   = '0;
          phase_nxt = DIST_ROOT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      DIST_ROOT: begin
        if (root_ge) begin
          sum_nxt = sum_r - trial[SUM_W-1:0];
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          phase_nxt = DIST_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        phase_nxt = DIST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= DIST_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    mx_r  <= mx_nxt;
    my_r  <= my_nxt;
    ax_r  <= ax_nxt;
    ay_r  <= ay_nxt;
    sum_r <= sum_nxt;
    bit_r <= bit_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.hypot = res_r[ROOT_W-1:0];

endmodule

// ----- hdl/pointer_activity_meter_top.sv -----
// Top level of the pointer activity meter: event decode, totals and ports.
// Instantiates pam_dist and depends on pam_pkg.
//
// Each accepted pointer, button or key transaction yields one result
// transaction with all totals after the event. An event that needs no
// distance goes from the decode state straight to the finish state; a
// counted move or a button event with a known earlier click also waits for
// the distance unit, which squares both deltas serially, then takes the root.
// One event is in work at a time; the result waits in an output register,
// so the next event is accepted while it is still stalled. Movement time is
// kept as seconds plus milliseconds, so the seconds total needs no divider.
// The configuration port is always ready; write it only while idle.
module pointer_activity_meter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic signed [15:0] in_x_pos,
  input  logic signed [15:0] in_y_pos,
  input  logic signed [15:0] in_wheel_step,
  input  logic        in_event_flag,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_movement_total,
  output logic [47:0] out_click_travel_total,
  output logic [31:0] out_click_count,
  output logic [31:0] out_keystroke_count,
  output logic [31:0] out_movement_seconds,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pam_pkg::*;

  pam_state_t state_r, state_nxt;

  logic        enable_r;
  logic [7:0]  min_step_r;
  logic [15:0] jump_limit_r;

  logic [1:0]  item_type_r;
  logic [15:0] item_x_r, item_y_r, item_wheel_r;
  logic        item_flag_r;
  logic [31:0] item_now_r;

  logic [DELTA_W-1:0] last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic               last_valid_r, last_valid_nxt;
  logic [DELTA_W-1:0] click_x_r, click_x_nxt, click_y_r, click_y_nxt;
  logic               click_valid_r, click_valid_nxt;
  logic [ACC_W-1:0]   travel_r, travel_nxt, click_travel_r, click_travel_nxt;
  logic [CNT32_W-1:0] press_r, press_nxt, key_r, key_nxt;
  logic [SEC_W-1:0]   secs_r, secs_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [31:0]        last_move_r, last_move_nxt;
  logic               to_click_r, to_click_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0]   out_travel_r, out_travel_nxt;
  logic [ACC_W-1:0]   out_click_travel_r, out_click_travel_nxt;
  logic [CNT32_W-1:0] out_press_r, out_press_nxt, out_key_r, out_key_nxt;
  logic [31:0]        out_secs_r, out_secs_nxt;

  dist_req_t dist_req;
  dist_rsp_t dist_rsp;

  pam_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dist_req),
    .rsp   (dist_rsp)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [15:0]        diff_x, diff_y;
    logic [DELTA_W-1:0] dx, dy, cdx, cdy;
    logic               move_ok, move_count;
    logic [31:0]        gap;
    logic [REM_W:0]     rsum;
    logic               carry;
    logic [REM_W-1:0]   rem2;
    logic [SEC_W:0]     secs2;
    logic [ACC_W:0]     acc_sum;
    state_nxt        = state_r;
    last_x_nxt       = last_x_r;
    last_y_nxt       = last_y_r;
    last_valid_nxt   = last_valid_r;
    click_x_nxt      = click_x_r;
    click_y_nxt      = click_y_r;
    click_valid_nxt  = click_valid_r;
    travel_nxt       = travel_r;
    click_travel_nxt = click_travel_r;
    press_nxt        = press_r;
    key_nxt          = key_r;
    secs_nxt         = secs_r;
    rem_nxt          = rem_r;
    last_move_nxt    = last_move_r;
    to_click_nxt     = to_click_r;
    out_valid_nxt        = out_valid_r & out_stall;
    out_travel_nxt       = out_travel_r;
    out_click_travel_nxt = out_click_travel_r;
    out_press_nxt        = out_press_r;
    out_key_nxt          = out_key_r;
    out_secs_nxt         = out_secs_r;
    dist_req.start = 1'b0;
    dist_req.dx    = '0;
    dist_req.dy    = '0;

    diff_x = (item_x_r >= {1'b0, last_x_r}) ? item_x_r - {1'b0, last_x_r}
                                             : {1'b0, last_x_r} - item_x_r;
    diff_y = (item_y_r >= {1'b0, last_y_r}) ? item_y_r - {1'b0, last_y_r}
                                             : {1'b0, last_y_r} - item_y_r;
    if (last_valid_r) begin
      dx = diff_x[DELTA_W-1:0];
      dy = diff_y[DELTA_W-1:0];
    end else begin
      dx = {{(DELTA_W-8){1'b0}}, min_step_r};
      dy = {{(DELTA_W-8){1'b0}}, min_step_r};
    end
    cdx = (click_x_r >= last_x_r) ? click_x_r - last_x_r : last_x_r - click_x_r;
    cdy = (click_y_r >= last_y_r) ? click_y_r - last_y_r : last_y_r - click_y_r;
    move_ok    = !item_x_r[15] && !item_y_r[15];
    move_count = ({1'b0, dx} < jump_limit_r) && ({1'b0, dy} < jump_limit_r) &&
                 ((dx >= {{(DELTA_W-8){1'b0}}, min_step_r}) ||
                  (dy >= {{(DELTA_W-8){1'b0}}, min_step_r}) ||
                  (item_wheel_r != '0));
    gap   = item_now_r - last_move_r;
    rsum  = {1'b0, rem_r} + {1'b0, gap[REM_W-1:0]};
    carry = (rsum >= MS_PER_SEC);
    rem2  = carry ? REM_W'(rsum - MS_PER_SEC) : rsum[REM_W-1:0];
    secs2 = {1'b0, secs_r} + {{SEC_W{1'b0}}, carry};
    acc_sum = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_FINISH;
        if (enable_r) begin
          case (item_type_r)
            REQ_MOVE: begin
              if (move_ok) begin
                last_x_nxt     = item_x_r[DELTA_W-1:0];
                last_y_nxt     = item_y_r[DELTA_W-1:0];
                last_valid_nxt = 1'b1;
                if (move_count) begin
                  if (gap < GAP_LIMIT) begin
                    if ((secs2 > {1'b0, SEC_MAX}) ||
                        ((secs2[SEC_W-1:0] == SEC_MAX) && (rem2 > REM_AT_SAT))) begin
                      secs_nxt = SEC_MAX;
                      rem_nxt  = REM_AT_SAT;
                    end else begin
                      secs_nxt = secs2[SEC_W-1:0];
                      rem_nxt  = rem2;
                    end
                  end
                  last_move_nxt  = item_now_r;
                  to_click_nxt   = 1'b0;
                  dist_req.start = 1'b1;
                  dist_req.dx    = dx;
                  dist_req.dy    = dy;
                  state_nxt      = ST_DIST;
                end
              end
            end
            REQ_BUTTON: begin
              if (click_valid_r && last_valid_r) begin
                to_click_nxt   = 1'b1;
                dist_req.start = 1'b1;
                dist_req.dx    = cdx;
                dist_req.dy    = cdy;
                state_nxt      = ST_DIST;
              end
              click_x_nxt     = last_x_r;
              click_y_nxt     = last_y_r;
              click_valid_nxt = last_valid_r;
              if (item_flag_r && (press_r != '1)) begin
                press_nxt = press_r + 1'b1;
              end
            end
            REQ_KEY: begin
              if (!item_flag_r && (key_r != '1)) begin
                key_nxt = key_r + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIST: begin
        if (dist_rsp.done) begin
          if (to_click_r) begin
            acc_sum = {1'b0, click_travel_r} + {{(ACC_W+1-ROOT_W){1'b0}}, dist_rsp.hypot};
            click_travel_nxt = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
          end else begin
            acc_sum = {1'b0, travel_r} + {{(ACC_W+1-ROOT_W){1'b0}}, dist_rsp.hypot};
            travel_nxt = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
          end
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_travel_nxt       = travel_r;
          out_click_travel_nxt = click_travel_r;
          out_press_nxt        = press_r;
          out_key_nxt          = key_r;
          out_secs_nxt = (secs_r[SEC_W-1:32] != '0) ? '1 : secs_r[31:0];
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= RESET_ENABLE;
      min_step_r   <= RESET_MIN_STEP;
      jump_limit_r <= RESET_JUMP_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_ENABLE:     enable_r     <= cfg_data[0];
        CFG_IDX_MIN_STEP:   min_step_r   <= cfg_data[7:0];
        CFG_IDX_JUMP_LIMIT: jump_limit_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r       <= '0;
      last_y_r       <= '0;
      last_valid_r   <= 1'b0;
      click_x_r      <= '0;
      click_y_r      <= '0;
      click_valid_r  <= 1'b0;
      travel_r       <= '0;
      click_travel_r <= '0;
      press_r        <= '0;
      key_r          <= '0;
      secs_r         <= '0;
      rem_r          <= '0;
      last_move_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      last_x_r       <= last_x_nxt;
      last_y_r       <= last_y_nxt;
      last_valid_r   <= last_valid_nxt;
      click_x_r      <= click_x_nxt;
      click_y_r      <= click_y_nxt;
      click_valid_r  <= click_valid_nxt;
      travel_r       <= travel_nxt;
      click_travel_r <= click_travel_nxt;
      press_r        <= press_nxt;
      key_r          <= key_nxt;
      secs_r         <= secs_nxt;
      rem_r          <= rem_nxt;
      last_move_r    <= last_move_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_type_r  <= in_req_type;
      item_x_r     <= in_x_pos;
      item_y_r     <= in_y_pos;
      item_wheel_r <= in_wheel_step;
      item_flag_r  <= in_event_flag;
      item_now_r   <= in_now_ms;
    end
    to_click_r         <= to_click_nxt;
    out_travel_r       <= out_travel_nxt;
    out_click_travel_r <= out_click_travel_nxt;
    out_press_r        <= out_press_nxt;
    out_key_r          <= out_key_nxt;
    out_secs_r         <= out_secs_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_movement_total     = out_travel_r;
  assign out_click_travel_total = out_click_travel_r;
  assign out_click_count        = out_press_r;
  assign out_keystroke_count    = out_key_r;
  assign out_movement_seconds   = out_secs_r;

endmodule
